### design/complex_decimating_fir_core_defines.svh
// Assertion macros for the complex decimating FIR core.
`ifndef COMPLEX_DECIMATING_FIR_CORE_DEFINES_SVH
`define COMPLEX_DECIMATING_FIR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define CDF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define CDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CDF_ASSERT_IMP(label, clk, rst, ante, cons)

`define CDF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/cdf_pkg.sv
// Shared types and constants of the complex decimating FIR core.
`timescale 1ns / 1ps
`default_nettype none

package cdf_pkg;

  localparam int DATA_W = 16;
  localparam int IDX_W  = 6;
  localparam int FAC_W  = 9;
  localparam int PH_W   = 8;
  localparam int FRAC_W = 15;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef logic signed [DATA_W-1:0] sample_t;

  typedef struct packed {
    logic clear;
    logic en;
    logic last;
  } mac_ctrl_t;

endpackage

`default_nettype wire

### design/complex_decimating_fir_core.sv
// Top level of the complex decimating FIR core: tap and history stores, sequencer, output register.
//
//  channel | direction | handshake             | payload
//  cfg     | in        | cfg_wen               | cfg_wdata (decimation factor)
//  in      | in        | in_valid / in_ready   | action, sample_i, sample_q, tap_index, tap_i, tap_q
//  out     | out       | out_valid / out_ready | out_i, out_q
//
// A tap load or a push that yields no output leaves the core idle, so in_ready stays high.
// A push that yields an output runs one complex MAC per tap
// through the shared multiplier unit, one read port per store.
// After reset a clearing pass zeroes every entry of both stores; in_ready stays low.
// A pending output word waits in the output register while new words are accepted;
// the next output holds the sequencer until that word is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_decimating_fir_core_defines.svh"

module complex_decimating_fir_core
  import cdf_pkg::*;
#(
  parameter int TAPS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic [FAC_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             action,
  input  wire sample_t          sample_i,
  input  wire sample_t          sample_q,
  input  wire logic [IDX_W-1:0] tap_index,
  input  wire sample_t          tap_i,
  input  wire sample_t          tap_q,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sample_t               out_i,
  output sample_t               out_q
);

  localparam int AW    = $clog2(TAPS);
  localparam int ACC_W = 2 * DATA_W + 1 + AW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  sample_t hist_i [TAPS];
  sample_t hist_q [TAPS];
  sample_t coef_i [TAPS];
  sample_t coef_q [TAPS];

  logic [2:0]       state, state_next;
  logic [AW-1:0]    write_ptr;
  logic [PH_W-1:0]  phase_count;
  logic [FAC_W-1:0] decimation_factor;
  logic [AW-1:0]    tap_cnt;
  logic [AW-1:0]    rd_ptr;
  logic             rd_en, rd_last;
  sample_t          hr_i, hr_q, cr_i, cr_q;

  logic             accept, push, load, load_ok, emit, issue, out_load;
  logic [FAC_W-1:0] factor, phase_step;
  logic [AW-1:0]    ptr_inc;
  logic [AW-1:0]    hist_waddr, coef_waddr;
  logic             hist_we, coef_we;
  sample_t          hist_wi, hist_wq, coef_wi, coef_wq;

  mac_ctrl_t        mac_ctrl;
  logic             mac_done;
  sample_t          mac_i, mac_q;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid & in_ready;
  assign push       = accept & (action == ACT_PUSH);
  assign load       = accept & (action == ACT_LOAD);
  assign load_ok    = load & (32'(tap_index) < TAPS);
  assign ptr_inc    = (write_ptr == LAST_ADDR) ? '0 : write_ptr + 1'b1;
  assign phase_step = FAC_W'(phase_count) + 1'b1;
  assign emit       = push & ~(phase_step < factor);
  assign issue      = (state == S_RUN);
  assign out_load   = (state == S_FINISH) & (~out_valid | out_ready);

  always_comb begin
    if (decimation_factor == '0) begin
      factor = FAC_W'(1);
    end else if (decimation_factor > FAC_W'(256)) begin
      factor = FAC_W'(256);
    end else begin
      factor = decimation_factor;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (tap_cnt == LAST_ADDR) state_next = S_IDLE;
      S_IDLE:   if (emit) state_next = S_RUN;
      S_RUN:    if (tap_cnt == LAST_ADDR) state_next = S_DRAIN;
      S_DRAIN:  if (mac_done) state_next = S_FINISH;
      S_FINISH: if (out_load) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      write_ptr         <= '0;
      phase_count       <= '0;
      decimation_factor <= FAC_W'(1);
      tap_cnt           <= '0;
      rd_ptr            <= '0;
      rd_en             <= 1'b0;
      rd_last           <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state   <= state_next;
      rd_en   <= issue;
      rd_last <= issue & (tap_cnt == LAST_ADDR);
      if (cfg_wen) begin
        decimation_factor <= cfg_wdata;
      end
      if (push) begin
        write_ptr   <= ptr_inc;
        phase_count <= emit ? '0 : phase_step[PH_W-1:0];
        rd_ptr      <= ptr_inc;
        tap_cnt     <= '0;
      end else if (state == S_CLEAR || state == S_RUN) begin
        tap_cnt <= (tap_cnt == LAST_ADDR) ? '0 : tap_cnt + 1'b1;
        rd_ptr  <= (rd_ptr == LAST_ADDR) ? '0 : rd_ptr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      hist_we    = 1'b1;
      coef_we    = 1'b1;
      hist_waddr = tap_cnt;
      coef_waddr = tap_cnt;
      hist_wi    = '0;
      hist_wq    = '0;
      coef_wi    = '0;
      coef_wq    = '0;
    end else begin
      hist_we    = push;
      coef_we    = load_ok;
      hist_waddr = write_ptr;
      coef_waddr = AW'(tap_index);
      hist_wi    = sample_i;
      hist_wq    = sample_q;
      coef_wi    = tap_i;
      coef_wq    = tap_q;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_i[hist_waddr] <= hist_wi;
      hist_q[hist_waddr] <= hist_wq;
    end
    if (issue) begin
      hr_i <= hist_i[rd_ptr];
      hr_q <= hist_q[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_i[coef_waddr] <= coef_wi;
      coef_q[coef_waddr] <= coef_wq;
    end
    if (issue) begin
      cr_i <= coef_i[tap_cnt];
      cr_q <= coef_q[tap_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_i <= mac_i;
      out_q <= mac_q;
    end
  end

  always_comb begin
    mac_ctrl.clear = (state == S_IDLE);
    mac_ctrl.en    = rd_en;
    mac_ctrl.last  = rd_last;
  end

  cdf_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .si   (hr_i),
    .sq   (hr_q),
    .ti   (cr_i),
    .tq   (cr_q),
    .done (mac_done),
    .res_i(mac_i),
    .res_q(mac_q)
  );

  `CDF_ASSERT_NEXT(a_emit_starts_run, clk, rst, emit, state == S_RUN)
  `CDF_ASSERT_IMP(a_done_in_drain, clk, rst, mac_done, state == S_DRAIN)
  `CDF_ASSERT_IMP(a_run_phase_clear, clk, rst, state == S_RUN, phase_count == '0)
  `CDF_ASSERT_NEXT(a_finish_loads_out, clk, rst, out_load, out_valid)

endmodule

`default_nettype wire

### design/cdf_mac.sv
// Shared complex multiply-accumulate unit with conjugated taps and output saturation.
`timescale 1ns / 1ps
`default_nettype none

module cdf_mac
  import cdf_pkg::*;
#(
  parameter int ACC_W = 39
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire mac_ctrl_t ctrl,
  input  wire sample_t   si,
  input  wire sample_t   sq,
  input  wire sample_t   ti,
  input  wire sample_t   tq,
  output logic           done,
  output sample_t        res_i,
  output sample_t        res_q
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sd32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32'sd32768);

  logic signed [PROD_W-1:0] p_ii, p_qq, p_qi, p_iq;
  logic signed [SUM_W-1:0]  sum_i, sum_q;
  logic signed [ACC_W-1:0]  acc_i, acc_q;
  logic signed [ACC_W-1:0]  sh_i, sh_q;
  logic v1, l1, v2, l2;

  always_ff @(posedge clk) begin
    p_ii  <= si * ti;
    p_qq  <= sq * tq;
    p_qi  <= sq * ti;
    p_iq  <= si * tq;
    sum_i <= SUM_W'(p_ii) + SUM_W'(p_qq);
    sum_q <= SUM_W'(p_qi) - SUM_W'(p_iq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      l1   <= 1'b0;
      v2   <= 1'b0;
      l2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= ctrl.en;
      l1   <= ctrl.en & ctrl.last;
      v2   <= v1;
      l2   <= v1 & l1;
      done <= v2 & l2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (v2) begin
      acc_i <= acc_i + ACC_W'(sum_i);
      acc_q <= acc_q + ACC_W'(sum_q);
    end
  end

  always_comb begin
    sh_i = acc_i >>> FRAC_W;
    sh_q = acc_q >>> FRAC_W;
    if (sh_i > SAT_MAX) begin
      res_i = SAT_MAX[DATA_W-1:0];
    end else if (sh_i < SAT_MIN) begin
      res_i = SAT_MIN[DATA_W-1:0];
    end else begin
      res_i = sh_i[DATA_W-1:0];
    end
    if (sh_q > SAT_MAX) begin
      res_q = SAT_MAX[DATA_W-1:0];
    end else if (sh_q < SAT_MIN) begin
      res_q = SAT_MIN[DATA_W-1:0];
    end else begin
      res_q = sh_q[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire
